[src/pps_pkg.sv]
// Shared types, codes and constants for the priority scheduler.
package pps_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int TIME_BITS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed widths of the channel fields
  localparam int SLOT_FIELD_W = 3;
  localparam int TIME_FIELD_W = 16;
  localparam int PRIO_FIELD_W = 8;
  localparam int SUM_W        = 32;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TURN,
    ST_WAIT,
    ST_EMIT
  } pps_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } pps_mem_ctl_t;

  typedef struct packed {
    logic clear;
    logic eval;
  } pps_pick_ctl_t;

endpackage

[src/pps_if.sv]
// Request and response channel interfaces.
interface pps_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [pps_pkg::SLOT_FIELD_W-1:0] slot;
  logic [pps_pkg::TIME_FIELD_W-1:0] arrival;
  logic [pps_pkg::TIME_FIELD_W-1:0] burst;
  logic [pps_pkg::PRIO_FIELD_W-1:0] priority_req;

  modport source (output valid, req_type, slot, arrival, burst, priority_req, input ready);
  modport sink   (input valid, req_type, slot, arrival, burst, priority_req, output ready);
endinterface

interface pps_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            idle;
  logic [pps_pkg::SLOT_FIELD_W-1:0] chosen_slot;
  logic                            finished;
  logic [pps_pkg::TIME_FIELD_W-1:0] waiting;
  logic [pps_pkg::TIME_FIELD_W-1:0] turnaround;
  logic [pps_pkg::SUM_W-1:0]        total_waiting;
  logic [pps_pkg::SUM_W-1:0]        total_turnaround;
  logic                            all_done;

  modport source (output valid, idle, chosen_slot, finished, waiting, turnaround,
                  total_waiting, total_turnaround, all_done, input ready);
  modport sink   (input valid, idle, chosen_slot, finished, waiting, turnaround,
                  total_waiting, total_turnaround, all_done, output ready);
endinterface

[src/pps_slot_store.sv]
// Job slot memory: one write port, one registered read port, per-entry valid bits.
module pps_slot_store #(
  parameter int DEPTH  = pps_pkg::NUM_SLOTS_DEF,
  parameter int WIDTH  = 3 * pps_pkg::TIME_BITS_DEF + pps_pkg::PRIO_BITS_DEF,
  parameter int ADDR_W = $clog2(pps_pkg::NUM_SLOTS_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pps_pkg::pps_mem_ctl_t ctl,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

[src/pps_picker.sv]
// Running selection over the slot stream: best ready job and count of busy slots.
module pps_picker #(
  parameter int SLOT_W    = $clog2(pps_pkg::NUM_SLOTS_DEF),
  parameter int CNT_W     = $clog2(pps_pkg::NUM_SLOTS_DEF + 1),
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pps_pkg::pps_pick_ctl_t ctl,
  input  logic [SLOT_W-1:0]     idx,
  input  logic [TIME_BITS-1:0]  arr,
  input  logic [TIME_BITS-1:0]  rem,
  input  logic [TIME_BITS-1:0]  bst,
  input  logic [PRIO_BITS-1:0]  prio,
  input  logic [TIME_BITS-1:0]  tick,
  output logic                  found,
  output logic [SLOT_W-1:0]     best_slot,
  output logic [TIME_BITS-1:0]  best_arr,
  output logic [TIME_BITS-1:0]  best_rem,
  output logic [TIME_BITS-1:0]  best_burst,
  output logic [PRIO_BITS-1:0]  best_prio,
  output logic [CNT_W-1:0]      busy_cnt
);

  logic busy;
  logic take;

  assign busy = (rem != '0);
  // strict compare keeps the lowest slot on a tie
  assign take = ctl.eval && busy && (arr <= tick) && (!found || (prio < best_prio));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found    <= 1'b0;
      busy_cnt <= '0;
    end else if (ctl.eval) begin
      if (take) begin
        found <= 1'b1;
      end
      if (busy) begin
        busy_cnt <= busy_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_slot  <= idx;
      best_arr   <= arr;
      best_rem   <= rem;
      best_burst <= bst;
      best_prio  <= prio;
    end
  end

endmodule

[src/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: job slots in a memory, one tick per scan.
//
// A load item writes one job slot; a load into a slot at or beyond NUM_SLOTS is dropped.
// A tick item scans all slots: the slot memory has one read port, so the scan reads
// one slot per cycle, and then the TURN, WAIT and EMIT states write back the remaining
// work, work out turnaround and waiting time and register the response. The next item
// is taken while a response still waits on the output; a further tick holds in its
// last step until that response is taken. The slot memory needs no clearing pass
// after reset: per-slot valid bits make unwritten slots read as empty.
module preemptive_priority_scheduler #(
  parameter int NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  pps_req_if.sink req,
  pps_rsp_if.source rsp
);

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int ENTRY_W = 3 * TIME_BITS + PRIO_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  pps_pkg::pps_state_t    state, state_next;
  pps_pkg::pps_mem_ctl_t  mem_ctl;
  pps_pkg::pps_pick_ctl_t pick_ctl;

  logic [SLOT_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [ENTRY_W-1:0]   rd_data;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 eval_vld;
  logic [SLOT_W-1:0]    eval_idx;
  logic                 emit;

  logic [TIME_BITS-1:0] tick;
  logic [TIME_BITS-1:0] end_tick;
  logic                 done;
  logic [TIME_BITS-1:0] tat;
  logic [TIME_BITS-1:0] wt;
  logic [pps_pkg::SUM_W-1:0] wait_sum;
  logic [pps_pkg::SUM_W-1:0] turn_sum;

  logic                 found;
  logic [SLOT_W-1:0]    best_slot;
  logic [TIME_BITS-1:0] best_arr, best_rem, best_burst;
  logic [PRIO_BITS-1:0] best_prio;
  logic [CNT_W-1:0]     busy_cnt;

  logic                 rsp_vld;
  logic                 rsp_idle;
  logic [pps_pkg::SLOT_FIELD_W-1:0] rsp_slot;
  logic                 rsp_fin;
  logic [pps_pkg::TIME_FIELD_W-1:0] rsp_wt;
  logic [pps_pkg::TIME_FIELD_W-1:0] rsp_tat;
  logic [pps_pkg::SUM_W-1:0] rsp_wsum;
  logic [pps_pkg::SUM_W-1:0] rsp_tsum;
  logic                 rsp_all_done;

  // entry layout: {arrival, remaining, burst, priority}
  pps_slot_store #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (issue_cnt[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  pps_picker #(
    .SLOT_W    (SLOT_W),
    .CNT_W     (CNT_W),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_picker (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pick_ctl),
    .idx        (eval_idx),
    .arr        (rd_data[ENTRY_W-1 -: TIME_BITS]),
    .rem        (rd_data[ENTRY_W-TIME_BITS-1 -: TIME_BITS]),
    .bst        (rd_data[PRIO_BITS +: TIME_BITS]),
    .prio       (rd_data[PRIO_BITS-1:0]),
    .tick       (tick),
    .found      (found),
    .best_slot  (best_slot),
    .best_arr   (best_arr),
    .best_rem   (best_rem),
    .best_burst (best_burst),
    .best_prio  (best_prio),
    .busy_cnt   (busy_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mem_ctl    = '0;
    pick_ctl   = '0;
    emit       = 1'b0;
    wr_addr    = SLOT_W'(req.slot);
    wr_data    = {TIME_BITS'(req.arrival), TIME_BITS'(req.burst), TIME_BITS'(req.burst),
                  PRIO_BITS'(req.priority_req)};
    unique case (state)
      pps_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.req_type == pps_pkg::REQ_TICK) begin
            pick_ctl.clear = 1'b1;
            state_next     = pps_pkg::ST_SCAN;
          end else begin
            mem_ctl.wr_en = (32'(req.slot) < NUM_SLOTS);
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        mem_ctl.rd_en = (issue_cnt < CNT_W'(NUM_SLOTS));
        pick_ctl.eval = eval_vld;
        if (eval_vld && (eval_idx == LAST_SLOT)) begin
          state_next = pps_pkg::ST_TURN;
        end
      end
      pps_pkg::ST_TURN: begin
        mem_ctl.wr_en = found;
        wr_addr       = best_slot;
        wr_data       = {best_arr, best_rem - TIME_BITS'(1), best_burst, best_prio};
        state_next    = pps_pkg::ST_WAIT;
      end
      pps_pkg::ST_WAIT: begin
        state_next = pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_EMIT: begin
        if (!rsp_vld || rsp.ready) begin
          emit       = 1'b1;
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // scan read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= mem_ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= issue_cnt[SLOT_W-1:0];
    if (state == pps_pkg::ST_IDLE) begin
      issue_cnt <= '0;
      end_tick  <= (tick == TIME_MAX) ? tick : tick + TIME_BITS'(1);
    end else if (mem_ctl.rd_en) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  // completion accounting; tat and wt stay zero unless the job completed
  always_ff @(posedge clk) begin
    if (state == pps_pkg::ST_TURN) begin
      done <= found && (best_rem == TIME_BITS'(1));
      tat  <= (found && (best_rem == TIME_BITS'(1)) && (end_tick > best_arr)) ?
              end_tick - best_arr : '0;
    end
    if (state == pps_pkg::ST_WAIT) begin
      wt <= (done && (tat > best_burst)) ? tat - best_burst : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick     <= '0;
      wait_sum <= '0;
      turn_sum <= '0;
    end else if (emit) begin
      tick     <= end_tick;
      wait_sum <= wait_sum + pps_pkg::SUM_W'(wt);
      turn_sum <= turn_sum + pps_pkg::SUM_W'(tat);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (emit) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_idle     <= !found;
      rsp_slot     <= found ? pps_pkg::SLOT_FIELD_W'(best_slot) : '0;
      rsp_fin      <= done;
      rsp_wt       <= pps_pkg::TIME_FIELD_W'(wt);
      rsp_tat      <= pps_pkg::TIME_FIELD_W'(tat);
      rsp_wsum     <= wait_sum + pps_pkg::SUM_W'(wt);
      rsp_tsum     <= turn_sum + pps_pkg::SUM_W'(tat);
      rsp_all_done <= (busy_cnt == CNT_W'(done));
    end
  end

  assign rsp.valid            = rsp_vld;
  assign rsp.idle             = rsp_idle;
  assign rsp.chosen_slot      = rsp_slot;
  assign rsp.finished         = rsp_fin;
  assign rsp.waiting          = rsp_wt;
  assign rsp.turnaround       = rsp_tat;
  assign rsp.total_waiting    = rsp_wsum;
  assign rsp.total_turnaround = rsp_tsum;
  assign rsp.all_done         = rsp_all_done;

endmodule

[src/pps_checker.sv]
// Port-level checks for the priority scheduler, bound to the top level.
module pps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic                            rsp_idle,
  input logic [pps_pkg::SLOT_FIELD_W-1:0] rsp_chosen_slot,
  input logic                            rsp_finished,
  input logic [pps_pkg::TIME_FIELD_W-1:0] rsp_waiting,
  input logic [pps_pkg::TIME_FIELD_W-1:0] rsp_turnaround,
  input logic [pps_pkg::SUM_W-1:0]        rsp_total_waiting
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_waiting)
      && $stable(rsp_chosen_slot) && $stable(rsp_finished))
    else $error("response changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_idle_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_idle |-> !rsp_finished && (rsp_chosen_slot == '0))
    else $error("idle tick reports a job");

  a_unfinished_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_finished |-> (rsp_waiting == '0) && (rsp_turnaround == '0))
    else $error("times reported for an unfinished job");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_idle          (rsp.idle),
  .rsp_chosen_slot   (rsp.chosen_slot),
  .rsp_finished      (rsp.finished),
  .rsp_waiting       (rsp.waiting),
  .rsp_turnaround    (rsp.turnaround),
  .rsp_total_waiting (rsp.total_waiting)
);
